// ===== rtl/tepq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tepq_pkg
// Shared constants, codes and controller/datapath types of the timed event
// priority queue.
// ----------------------------------------------------------------------------
package tepq_pkg;

    localparam int DEF_CAPACITY  = 64;
    localparam int DEF_TIME_BITS = 32;
    localparam int DEF_TAG_BITS  = 16;
    localparam int SEQ_BITS      = 32;
    localparam int HORIZON_BITS  = 32;
    localparam int ACTION_BITS   = 2;

    localparam logic [HORIZON_BITS-1:0] HORIZON_RESET = '1;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_INSERT     = 2'd0,
        ACT_INSERT_END = 2'd1,
        ACT_POP        = 2'd2
    } t_action;

    typedef struct packed {
        logic in_ready;
        logic scan_clear;
        logic scan_rd;
        logic move_rd;
        logic commit_ins;
        logic commit_pop;
        logic commit_nop;
    } t_dp_cmd;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic is_ins;
        logic is_pop;
        logic count_zero;
        logic scan_last;
    } t_dp_stat;

endpackage

// ===== rtl/tepq_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tepq_ifs
// Valid/ready channels of the queue: event requests in, step results out.
// ----------------------------------------------------------------------------
interface tepq_evt_if
    import tepq_pkg::*;
#(
    parameter int TIME_BITS = DEF_TIME_BITS,
    parameter int TAG_BITS  = DEF_TAG_BITS
);
    logic                   valid;
    logic                   ready;
    logic [ACTION_BITS-1:0] action;
    logic [TIME_BITS-1:0]   event_time;
    logic [TAG_BITS-1:0]    event_tag;

    modport source (output valid, action, event_time, event_tag, input ready);
    modport sink   (input valid, action, event_time, event_tag, output ready);
endinterface

interface tepq_res_if
    import tepq_pkg::*;
#(
    parameter int TIME_BITS = DEF_TIME_BITS,
    parameter int TAG_BITS  = DEF_TAG_BITS,
    parameter int OCC_BITS  = $clog2(DEF_CAPACITY + 1)
);
    logic                 valid;
    logic                 ready;
    logic                 pop_valid;
    logic [TIME_BITS-1:0] popped_time;
    logic [TAG_BITS-1:0]  popped_tag;
    logic [SEQ_BITS-1:0]  popped_sequence;
    logic                 dropped;
    logic [OCC_BITS-1:0]  occupancy;

    modport source (output valid, pop_valid, popped_time, popped_tag, popped_sequence,
                    dropped, occupancy, input ready);
    modport sink   (input valid, pop_valid, popped_time, popped_tag, popped_sequence,
                    dropped, occupancy, output ready);
endinterface

// ===== rtl/tepq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tepq_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tepq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tepq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tepq_ctrl
// Sequencer of the queue: accept, execute insert or no-op, scan for the earliest
// entry, move the last entry into the freed slot.
// ----------------------------------------------------------------------------
module tepq_ctrl
    import tepq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_SCAN_END,
        ST_MOVE_RD,
        ST_MOVE_WR
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                priority if (i_stat.is_ins) begin
                    if (i_stat.out_free) begin
                        o_cmd.commit_ins = 1'b1;
                        n_state          = ST_IDLE;
                    end
                end else if (i_stat.is_pop && !i_stat.count_zero) begin
                    o_cmd.scan_clear = 1'b1;
                    n_state          = ST_SCAN;
                end else begin
                    if (i_stat.out_free) begin
                        o_cmd.commit_nop = 1'b1;
                        n_state          = ST_IDLE;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                n_state = ST_MOVE_RD;
            end
            ST_MOVE_RD: begin
                o_cmd.move_rd = 1'b1;
                n_state       = ST_MOVE_WR;
            end
            ST_MOVE_WR: begin
                if (i_stat.out_free) begin
                    o_cmd.commit_pop = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/tepq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tepq_dp
// Datapath of the queue: dense entry RAM, count, sequence counter, horizon
// register, earliest-entry scan and the result register.
// ----------------------------------------------------------------------------
module tepq_dp
    import tepq_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int TIME_BITS = DEF_TIME_BITS,
    parameter int TAG_BITS  = DEF_TAG_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [HORIZON_BITS-1:0] i_cfg_wdata,
    tepq_evt_if.sink                i_evt,
    tepq_res_if.source              o_res,
    input  t_dp_cmd                 i_cmd,
    output t_dp_stat                o_stat
);

    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int OCC_BITS = $clog2(CAPACITY + 1);
    localparam int WORD_W   = TIME_BITS + SEQ_BITS + TAG_BITS;
    localparam int CMP_W    = (TIME_BITS > HORIZON_BITS) ? TIME_BITS : HORIZON_BITS;

    logic [HORIZON_BITS-1:0] r_horizon;
    logic [SEQ_BITS-1:0]     r_seq;
    logic [OCC_BITS-1:0]     r_count;
    logic                    r_rd_vld;
    logic                    r_have_best;
    logic                    r_out_valid;

    logic [ACTION_BITS-1:0]  r_action;
    logic [TIME_BITS-1:0]    r_time;
    logic [TAG_BITS-1:0]     r_tag;
    logic [ADDR_W-1:0]       r_scan_idx;
    logic [ADDR_W-1:0]       r_rd_idx;
    logic [ADDR_W-1:0]       r_best_idx;
    logic [TIME_BITS-1:0]    r_best_time;
    logic [SEQ_BITS-1:0]     r_best_seq;
    logic [TAG_BITS-1:0]     r_best_tag;
    logic                    r_out_pop_valid;
    logic [TIME_BITS-1:0]    r_out_time;
    logic [TAG_BITS-1:0]     r_out_tag;
    logic [SEQ_BITS-1:0]     r_out_seq;
    logic                    r_out_dropped;
    logic [OCC_BITS-1:0]     r_out_occ;

    logic [ADDR_W-1:0]    last_idx;
    logic                 is_plain;
    logic                 is_ins;
    logic                 is_pop;
    logic                 beyond;
    logic                 full;
    logic                 drop;
    logic                 take;
    logic                 out_free;
    logic                 accept;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [WORD_W-1:0]    ram_rdata;
    logic [TIME_BITS-1:0] rd_time;
    logic [SEQ_BITS-1:0]  rd_seq;
    logic [TAG_BITS-1:0]  rd_tag;

    assign rd_time = ram_rdata[WORD_W-1 -: TIME_BITS];
    assign rd_seq  = ram_rdata[TAG_BITS +: SEQ_BITS];
    assign rd_tag  = ram_rdata[TAG_BITS-1:0];

    assign last_idx = ADDR_W'(r_count - OCC_BITS'(1));
    assign is_plain = (r_action == ACT_INSERT);
    assign is_ins   = is_plain || (r_action == ACT_INSERT_END);
    assign is_pop   = (r_action == ACT_POP);
    assign beyond   = CMP_W'(r_time) > CMP_W'(r_horizon);
    assign full     = (r_count >= OCC_BITS'(CAPACITY));
    assign drop     = (is_plain && beyond) || full;
    assign take     = !r_have_best || (rd_time < r_best_time)
                   || ((rd_time == r_best_time) && (rd_seq < r_best_seq));
    assign out_free = !r_out_valid || o_res.ready;
    assign accept   = i_cmd.in_ready && i_evt.valid;

    assign ram_we    = (i_cmd.commit_ins && !drop) || i_cmd.commit_pop;
    assign ram_waddr = i_cmd.commit_pop ? r_best_idx : ADDR_W'(r_count);
    assign ram_wdata = i_cmd.commit_pop ? ram_rdata : {r_time, r_seq, r_tag};
    assign ram_re    = i_cmd.scan_rd || i_cmd.move_rd;
    assign ram_raddr = i_cmd.move_rd ? last_idx : r_scan_idx;

    tepq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_stat.in_valid   = i_evt.valid;
        o_stat.out_free   = out_free;
        o_stat.is_ins     = is_ins;
        o_stat.is_pop     = is_pop;
        o_stat.count_zero = (r_count == '0);
        o_stat.scan_last  = (r_scan_idx == last_idx);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_horizon   <= HORIZON_RESET;
            r_seq       <= '0;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_have_best <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_horizon <= i_cfg_wdata;
            end
            r_rd_vld <= i_cmd.scan_rd;
            if (i_cmd.scan_clear) begin
                r_have_best <= 1'b0;
            end else if (r_rd_vld) begin
                r_have_best <= 1'b1;
            end
            if (i_cmd.commit_ins) begin
                r_seq <= r_seq + SEQ_BITS'(1);
                if (!drop) begin
                    r_count <= r_count + OCC_BITS'(1);
                end
            end else if (i_cmd.commit_pop) begin
                r_count <= r_count - OCC_BITS'(1);
            end
            if (i_cmd.commit_ins || i_cmd.commit_pop || i_cmd.commit_nop) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_evt.action;
            r_time   <= i_evt.event_time;
            r_tag    <= i_evt.event_tag;
        end
        if (i_cmd.scan_clear) begin
            r_scan_idx <= '0;
        end else if (i_cmd.scan_rd) begin
            r_scan_idx <= r_scan_idx + ADDR_W'(1);
        end
        r_rd_idx <= r_scan_idx;
        if (r_rd_vld && take) begin
            r_best_idx  <= r_rd_idx;
            r_best_time <= rd_time;
            r_best_seq  <= rd_seq;
            r_best_tag  <= rd_tag;
        end
        if (i_cmd.commit_ins) begin
            r_out_pop_valid <= 1'b0;
            r_out_time      <= '0;
            r_out_tag       <= '0;
            r_out_seq       <= '0;
            r_out_dropped   <= drop;
            r_out_occ       <= drop ? r_count : r_count + OCC_BITS'(1);
        end else if (i_cmd.commit_pop) begin
            r_out_pop_valid <= 1'b1;
            r_out_time      <= r_best_time;
            r_out_tag       <= r_best_tag;
            r_out_seq       <= r_best_seq;
            r_out_dropped   <= 1'b0;
            r_out_occ       <= r_count - OCC_BITS'(1);
        end else if (i_cmd.commit_nop) begin
            r_out_pop_valid <= 1'b0;
            r_out_time      <= '0;
            r_out_tag       <= '0;
            r_out_seq       <= '0;
            r_out_dropped   <= 1'b0;
            r_out_occ       <= r_count;
        end
    end

    assign i_evt.ready           = i_cmd.in_ready;
    assign o_res.valid           = r_out_valid;
    assign o_res.pop_valid       = r_out_pop_valid;
    assign o_res.popped_time     = r_out_time;
    assign o_res.popped_tag      = r_out_tag;
    assign o_res.popped_sequence = r_out_seq;
    assign o_res.dropped         = r_out_dropped;
    assign o_res.occupancy       = r_out_occ;

endmodule

// ===== rtl/timed_event_priority_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_event_priority_queue_core
// Discrete-event scheduler queue: insert timed events, pop the earliest
// (lowest time, then lowest sequence number).
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake     Carries
// i_evt    in   valid/ready   action, event_time, event_tag
// o_res    out  valid/ready   pop_valid, popped_time, popped_tag,
//                             popped_sequence, dropped, occupancy
// i_cfg    in   write enable  horizon_ticks
//
// Insert, no-op, empty pop: the result is registered; a new request waits until it commits.
// Pop of n stored events: scan of all n entries, then move of the last entry into
// the freed slot; the scan reads one entry per cycle through the RAM read port.
// Synchronous reset empties the queue at once, no clearing pass.
// A finished result holds in the output register while the next item is taken;
// stall only to commit a result while the last one waits.
// ----------------------------------------------------------------------------
module timed_event_priority_queue_core
    import tepq_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int TIME_BITS = DEF_TIME_BITS,
    parameter int TAG_BITS  = DEF_TAG_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [HORIZON_BITS-1:0] i_cfg_wdata,
    tepq_evt_if.sink                i_evt,
    tepq_res_if.source              o_res
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    tepq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    tepq_dp #(
        .CAPACITY  (CAPACITY),
        .TIME_BITS (TIME_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_evt       (i_evt),
        .o_res       (o_res),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for timed_event_priority_queue_core. A scoreboard
// class keeps its own copy of the event store, predicts the result of each
// accepted request and checks the results in order. Directed requests cover
// empty pops, ties, the horizon edge and end events. Random phases follow,
// with varied horizons, idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import tepq_pkg::*;

    localparam int CAPACITY    = DEF_CAPACITY;
    localparam int TIME_W      = DEF_TIME_BITS;
    localparam int TAG_W       = DEF_TAG_BITS;
    localparam int OCC_W       = $clog2(DEF_CAPACITY + 1);
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 170;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = CAPACITY + 16;
    localparam int MAX_PRINTS  = 100;

    localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic                pop_valid;
        logic [TIME_W-1:0]   popped_time;
        logic [TAG_W-1:0]    popped_tag;
        logic [SEQ_BITS-1:0] popped_sequence;
        logic                dropped;
        logic [OCC_W-1:0]    occupancy;
    } t_step_result;

    class event_order_scoreboard;
        logic [TIME_W-1:0]       slot_time [CAPACITY];
        logic [SEQ_BITS-1:0]     slot_seq  [CAPACITY];
        logic [TAG_W-1:0]        slot_tag  [CAPACITY];
        bit                      slot_used [CAPACITY];
        logic [SEQ_BITS-1:0]     seq_next;
        logic [HORIZON_BITS-1:0] horizon;
        int                      stored;
        int                      errors;
        t_step_result            expected_results [$];

        function new();
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            seq_next = '0;
            horizon  = HORIZON_RESET;
            stored   = 0;
            errors   = 0;
        endfunction

        task report_mismatch(input string msg);
            errors++;
            if (errors <= MAX_PRINTS) begin
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            end
        endtask

        task note_request(input logic [ACTION_BITS-1:0] act, input logic [TIME_W-1:0] t,
                          input logic [TAG_W-1:0] tag);
            t_step_result r;
            int best;
            r = '{default: '0};
            best = -1;
            case (act)
                ACT_INSERT, ACT_INSERT_END: begin
                    if (act == ACT_INSERT && t > horizon) begin
                        r.dropped = 1'b1;
                    end else if (stored >= CAPACITY) begin
                        r.dropped = 1'b1;
                    end else begin
                        for (int i = 0; i < CAPACITY; i++) begin
                            if (!slot_used[i] && best < 0) begin
                                best = i;
                            end
                        end
                        slot_used[best] = 1'b1;
                        slot_time[best] = t;
                        slot_seq[best]  = seq_next;
                        slot_tag[best]  = tag;
                        stored++;
                    end
                    seq_next = seq_next + 1'b1;
                end
                ACT_POP: begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (slot_used[i] && (best < 0 || slot_time[i] < slot_time[best] ||
                            (slot_time[i] == slot_time[best] && slot_seq[i] < slot_seq[best])))
                        begin
                            best = i;
                        end
                    end
                    if (best >= 0) begin
                        r.pop_valid       = 1'b1;
                        r.popped_time     = slot_time[best];
                        r.popped_tag      = slot_tag[best];
                        r.popped_sequence = slot_seq[best];
                        slot_used[best]   = 1'b0;
                        stored--;
                    end
                end
                default: begin
                end
            endcase
            r.occupancy = OCC_W'(stored);
            expected_results = {expected_results, r};
        endtask

        task compare_field(input string name, input logic [31:0] got, input logic [31:0] exp);
            if (got !== exp) begin
                report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, exp));
            end
        endtask

        task check_result(input t_step_result got);
            t_step_result exp;
            if (expected_results.size() == 0) begin
                report_mismatch("result transfer with no request outstanding");
            end else begin
                exp = expected_results.pop_front();
                compare_field("pop_valid", 32'(got.pop_valid), 32'(exp.pop_valid));
                compare_field("popped_time", 32'(got.popped_time), 32'(exp.popped_time));
                compare_field("popped_tag", 32'(got.popped_tag), 32'(exp.popped_tag));
                compare_field("popped_sequence", got.popped_sequence, exp.popped_sequence);
                compare_field("dropped", 32'(got.dropped), 32'(exp.dropped));
                compare_field("occupancy", 32'(got.occupancy), 32'(exp.occupancy));
            end
        endtask
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [HORIZON_BITS-1:0] i_cfg_wdata;
    int                      gap_pct;
    int                      stall_pct;
    bit                      hold_request;

    event_order_scoreboard sb = new();

    tepq_evt_if evt_if ();
    tepq_res_if res_if ();

    timed_event_priority_queue_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_evt       (evt_if),
        .o_res       (res_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int n = 0;
        while (n < 16 && $urandom_range(99) < gap_pct) n++;
        return n;
    endfunction

    task automatic offer_request(input logic [ACTION_BITS-1:0] act,
                                 input logic [TIME_W-1:0] t, input logic [TAG_W-1:0] tag);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            evt_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        evt_if.valid      <= 1'b1;
        evt_if.action     <= act;
        evt_if.event_time <= t;
        evt_if.event_tag  <= tag;
        do @(posedge i_clk); while (evt_if.ready !== 1'b1);
        sb.note_request(act, t, tag);
    endtask

    task automatic await_empty_queue();
        evt_if.valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_horizon(input logic [HORIZON_BITS-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.horizon = value;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n !== 1'b1) begin
                res_if.ready <= 1'b0;
            end else if (hold_left != 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (hold_request && !hold_done) begin
                res_if.ready <= 1'b0;
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                res_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_step_result got;
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            got.pop_valid       = res_if.pop_valid;
            got.popped_time     = res_if.popped_time;
            got.popped_tag      = res_if.popped_tag;
            got.popped_sequence = res_if.popped_sequence;
            got.dropped         = res_if.dropped;
            got.occupancy       = res_if.occupancy;
            sb.check_result(got);
        end
    end

    initial begin
        logic [HORIZON_BITS-1:0] horizons [PHASES];
        logic [ACTION_BITS-1:0]  act;
        logic [TIME_W-1:0]       t;
        int                      bias;
        int                      r;
        int                      k;
        int                      ins_w;
        int                      end_w;
        int                      pop_w;

        gap_pct      = 0;
        stall_pct    = 0;
        hold_request = 1'b0;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        evt_if.valid      <= 1'b0;
        evt_if.action     <= ACT_INSERT;
        evt_if.event_time <= '0;
        evt_if.event_tag  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // horizon at reset value: edge times, ties, end events, unused code
        offer_request(ACT_POP, '0, '0);
        offer_request(ACT_UNUSED, '1, '1);
        offer_request(ACT_INSERT, '1, '1);
        offer_request(ACT_INSERT, '0, '0);
        offer_request(ACT_INSERT, 32'd5, 16'h0001);
        offer_request(ACT_INSERT, 32'd5, 16'h0002);
        offer_request(ACT_INSERT_END, 32'd5, 16'h0003);
        offer_request(ACT_INSERT_END, '0, 16'hAAAA);
        repeat (7) offer_request(ACT_POP, '0, '0);
        await_empty_queue();

        set_horizon(32'd100);
        offer_request(ACT_INSERT, 32'd100, 16'h5555);
        offer_request(ACT_INSERT, 32'd101, 16'h1234);
        offer_request(ACT_INSERT_END, '1, 16'h8001);
        repeat (2) offer_request(ACT_POP, '0, '0);
        await_empty_queue();

        set_horizon('0);
        offer_request(ACT_INSERT, '0, 16'h00FF);
        offer_request(ACT_INSERT, 32'd1, 16'hFF00);
        offer_request(ACT_INSERT_END, 32'd1, 16'h7FFF);
        repeat (2) offer_request(ACT_POP, '0, '0);

        horizons = '{32'hFFFF_FFFF, 32'h0, $urandom, 32'h0000_0040,
                     32'hFFFF_FFFF, $urandom, 32'h7FFF_FFFF, $urandom};

        for (int p = 0; p < PHASES; p++) begin
            await_empty_queue();
            set_horizon(horizons[p]);
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 56; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 56; end
                default: begin gap_pct = 25; stall_pct = 25; end
            endcase
            bias = (p + 2) % 3;
            case (bias)
                0: begin ins_w = 70; end_w = 10; pop_w = 17; end
                1: begin ins_w = 45; end_w = 5;  pop_w = 47; end
                default: begin ins_w = 25; end_w = 5; pop_w = 67; end
            endcase
            if (p == 4) hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(99);
                if (r < ins_w) act = ACT_INSERT;
                else if (r < ins_w + end_w) act = ACT_INSERT_END;
                else if (r < ins_w + end_w + pop_w) act = ACT_POP;
                else act = ACT_UNUSED;
                k = $urandom_range(9);
                if (k < 4) t = TIME_W'($urandom_range(15));
                else if (k < 6) t = sb.horizon + TIME_W'($urandom_range(4)) - TIME_W'(2);
                else t = $urandom;
                offer_request(act, t, TAG_W'($urandom_range(16'hFFFF)));
            end
        end

        await_empty_queue();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
